// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned WIN_WORDS   = 16;
   localparam int unsigned ROUNDS      = 64;

   localparam byte_type PAD_MARK     = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type x, input word_type y,
                                       input word_type z);
      choose = (x & y) ^ (~x & z);
   endfunction

   function automatic word_type majority(input word_type x, input word_type y,
                                         input word_type z);
      majority = (x & y) ^ (x & z) ^ (y & z);
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      case (idx)
         3'd0:    init_hash = 32'h6a09e667;
         3'd1:    init_hash = 32'hbb67ae85;
         3'd2:    init_hash = 32'h3c6ef372;
         3'd3:    init_hash = 32'ha54ff53a;
         3'd4:    init_hash = 32'h510e527f;
         3'd5:    init_hash = 32'h9b05688c;
         3'd6:    init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic word_type round_const(input logic [5:0] idx);
      case (idx)
         6'd0:    round_const = 32'h428a2f98;
         6'd1:    round_const = 32'h71374491;
         6'd2:    round_const = 32'hb5c0fbcf;
         6'd3:    round_const = 32'he9b5dba5;
         6'd4:    round_const = 32'h3956c25b;
         6'd5:    round_const = 32'h59f111f1;
         6'd6:    round_const = 32'h923f82a4;
         6'd7:    round_const = 32'hab1c5ed5;
         6'd8:    round_const = 32'hd807aa98;
         6'd9:    round_const = 32'h12835b01;
         6'd10:   round_const = 32'h243185be;
         6'd11:   round_const = 32'h550c7dc3;
         6'd12:   round_const = 32'h72be5d74;
         6'd13:   round_const = 32'h80deb1fe;
         6'd14:   round_const = 32'h9bdc06a7;
         6'd15:   round_const = 32'hc19bf174;
         6'd16:   round_const = 32'he49b69c1;
         6'd17:   round_const = 32'hefbe4786;
         6'd18:   round_const = 32'h0fc19dc6;
         6'd19:   round_const = 32'h240ca1cc;
         6'd20:   round_const = 32'h2de92c6f;
         6'd21:   round_const = 32'h4a7484aa;
         6'd22:   round_const = 32'h5cb0a9dc;
         6'd23:   round_const = 32'h76f988da;
         6'd24:   round_const = 32'h983e5152;
         6'd25:   round_const = 32'ha831c66d;
         6'd26:   round_const = 32'hb00327c8;
         6'd27:   round_const = 32'hbf597fc7;
         6'd28:   round_const = 32'hc6e00bf3;
         6'd29:   round_const = 32'hd5a79147;
         6'd30:   round_const = 32'h06ca6351;
         6'd31:   round_const = 32'h14292967;
         6'd32:   round_const = 32'h27b70a85;
         6'd33:   round_const = 32'h2e1b2138;
         6'd34:   round_const = 32'h4d2c6dfc;
         6'd35:   round_const = 32'h53380d13;
         6'd36:   round_const = 32'h650a7354;
         6'd37:   round_const = 32'h766a0abb;
         6'd38:   round_const = 32'h81c2c92e;
         6'd39:   round_const = 32'h92722c85;
         6'd40:   round_const = 32'ha2bfe8a1;
         6'd41:   round_const = 32'ha81a664b;
         6'd42:   round_const = 32'hc24b8b70;
         6'd43:   round_const = 32'hc76c51a3;
         6'd44:   round_const = 32'hd192e819;
         6'd45:   round_const = 32'hd6990624;
         6'd46:   round_const = 32'hf40e3585;
         6'd47:   round_const = 32'h106aa070;
         6'd48:   round_const = 32'h19a4c116;
         6'd49:   round_const = 32'h1e376c08;
         6'd50:   round_const = 32'h2748774c;
         6'd51:   round_const = 32'h34b0bcb5;
         6'd52:   round_const = 32'h391c0cb3;
         6'd53:   round_const = 32'h4ed8aa4a;
         6'd54:   round_const = 32'h5b9cca4f;
         6'd55:   round_const = 32'h682e6ff3;
         6'd56:   round_const = 32'h748f82ee;
         6'd57:   round_const = 32'h78a5636f;
         6'd58:   round_const = 32'h84c87814;
         6'd59:   round_const = 32'h8cc70208;
         6'd60:   round_const = 32'h90befffa;
         6'd61:   round_const = 32'ha4506ceb;
         6'd62:   round_const = 32'hbef9a3f7;
         default: round_const = 32'hc67178f2;
      endcase
   endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: data_byte; tuser: byte_present;
//                                       tlast: message_end
// rsp       out  rsp_tvalid/rsp_tready  tdata: digest_word; tuser: word_index;
//                                       tlast: last_word
//
// One request per cycle while gathering bytes. The request that completes a
// 64-byte block holds req_tready low while the working variables are loaded
// from the hash memory, the 64 rounds run and the results are added back.
// At message end the padding is fed one byte per cycle, between compressions,
// through the same path (one or two extra blocks); each digest word then waits
// for rsp_tready. Reset clears control state and the hash valid bits only.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;
   localparam logic [2:0] ST_ORD   = 3'd5;
   localparam logic [2:0] ST_OLOAD = 3'd6;
   localparam logic [2:0] ST_OWAIT = 3'd7;

   localparam logic [1:0] RET_IDLE = 2'd0;
   localparam logic [1:0] RET_PAD  = 2'd1;
   localparam logic [1:0] RET_OUT  = 2'd2;

   localparam logic [3:0] STEP_LAST = 4'(sha256_pkg::HASH_WORDS);
   localparam logic [5:0] RND_LAST  = 6'(sha256_pkg::ROUNDS - 1);
   localparam logic [5:0] FILL_LAST = 6'(sha256_pkg::BLOCK_BYTES - 1);
   localparam logic [5:0] RND_SCHED = 6'(sha256_pkg::WIN_WORDS);

   logic [2:0]  state_ff, state_in;
   logic [1:0]  ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic [23:0] part_ff, part_in;
   logic        mark_ff, mark_in;
   logic        lenph_ff, lenph_in;
   logic [3:0]  step_ff, step_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   sha256_pkg::word_type wv_ff [sha256_pkg::HASH_WORDS];
   sha256_pkg::word_type wv_in [sha256_pkg::HASH_WORDS];
   sha256_pkg::word_type win_ff [sha256_pkg::WIN_WORDS];
   sha256_pkg::word_type win_in [sha256_pkg::WIN_WORDS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   // block buffer: 16 big-endian words
   sha256_pkg::word_type bmem [sha256_pkg::WIN_WORDS];
   sha256_pkg::word_type bq_ff;
   logic [3:0]  brd_addr;

   // hash words; an entry not yet written reads as the initial value
   sha256_pkg::word_type hmem [sha256_pkg::HASH_WORDS];
   logic [7:0]  hval_ff, hval_in;
   sha256_pkg::word_type hq_ff;
   logic        hqv_ff;
   logic [2:0]  hqa_ff;
   logic [2:0]  hrd_addr;
   logic        hwr_en;
   logic [2:0]  hwr_addr;
   sha256_pkg::word_type hwr_data;
   sha256_pkg::word_type hword;

   logic        req_fire;
   logic        put_en;
   sha256_pkg::byte_type put_byte;
   logic        block_full;
   logic        len_sel;
   logic [63:0] len_bits;
   logic [63:0] len_shift;
   sha256_pkg::byte_type pad_byte;
   sha256_pkg::word_type sched_w;
   sha256_pkg::word_type round_w;
   sha256_pkg::word_type t1;
   sha256_pkg::word_type t2;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign hword = hqv_ff ? hq_ff : sha256_pkg::init_hash(hqa_ff);

   // padding byte source
   assign len_bits  = {count_ff, 3'b000};
   assign len_shift = len_bits >> {~fill_ff[2:0], 3'b000};
   assign len_sel   = lenph_ff || (!mark_ff && (fill_ff == sha256_pkg::LEN_OFFSET));
   assign pad_byte  = mark_ff ? sha256_pkg::PAD_MARK :
                      (len_sel ? len_shift[7:0] : 8'h00);

   assign put_en     = (state_ff == ST_PAD) || (req_fire && req_tuser);
   assign put_byte   = (state_ff == ST_PAD) ? pad_byte : req_tdata;
   assign block_full = put_en && (fill_ff == FILL_LAST);

   // round datapath
   assign sched_w = sha256_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                  + sha256_pkg::small_sigma0(win_ff[1]) + win_ff[0];
   assign round_w = (rnd_ff < RND_SCHED) ? bq_ff : sched_w;
   assign t1 = wv_ff[7] + sha256_pkg::big_sigma1(wv_ff[4])
             + sha256_pkg::choose(wv_ff[4], wv_ff[5], wv_ff[6])
             + sha256_pkg::round_const(rnd_ff) + round_w;
   assign t2 = sha256_pkg::big_sigma0(wv_ff[0])
             + sha256_pkg::majority(wv_ff[0], wv_ff[1], wv_ff[2]);

   assign brd_addr = (state_ff == ST_ROUND) ? (rnd_ff[3:0] + 4'd1) : 4'd0;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      part_in      = part_ff;
      mark_in      = mark_ff;
      lenph_in     = lenph_ff;
      step_in      = step_ff;
      rnd_in       = rnd_ff;
      oidx_in      = oidx_ff;
      wv_in        = wv_ff;
      win_in       = win_ff;
      hval_in      = hval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      hrd_addr     = step_ff[2:0];
      hwr_en       = 1'b0;
      hwr_addr     = 3'(step_ff - 4'd1);
      hwr_data     = hword + wv_ff[0];

      if (put_en) begin
         fill_in = fill_ff + 6'd1;
         part_in = {part_ff[15:0], put_byte};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  count_in = count_ff + 61'd1;
               end
               if (req_tlast) begin
                  mark_in  = 1'b1;
                  lenph_in = 1'b0;
               end
               if (block_full) begin
                  state_in = ST_LOAD;
                  step_in  = 4'd0;
                  ret_in   = req_tlast ? RET_PAD : RET_IDLE;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            mark_in  = 1'b0;
            lenph_in = len_sel;
            if (block_full) begin
               state_in = ST_LOAD;
               step_in  = 4'd0;
               ret_in   = len_sel ? RET_OUT : RET_PAD;
            end
         end
         ST_LOAD: begin
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               for (int j = 0; j < sha256_pkg::HASH_WORDS - 1; j++) begin
                  wv_in[j] = wv_ff[j + 1];
               end
               wv_in[sha256_pkg::HASH_WORDS - 1] = hword;
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_ROUND;
               rnd_in   = 6'd0;
            end
         end
         ST_ROUND: begin
            for (int j = 0; j < sha256_pkg::WIN_WORDS - 1; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[sha256_pkg::WIN_WORDS - 1] = round_w;
            wv_in[0] = t1 + t2;
            wv_in[1] = wv_ff[0];
            wv_in[2] = wv_ff[1];
            wv_in[3] = wv_ff[2];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[5] = wv_ff[4];
            wv_in[6] = wv_ff[5];
            wv_in[7] = wv_ff[6];
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == RND_LAST) begin
               state_in = ST_FINAL;
               step_in  = 4'd0;
            end
         end
         ST_FINAL: begin
            // read entry k while writing entry k-1: never the same entry
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               hwr_en = 1'b1;
               hval_in[hwr_addr] = 1'b1;
               for (int j = 0; j < sha256_pkg::HASH_WORDS - 1; j++) begin
                  wv_in[j] = wv_ff[j + 1];
               end
            end
            if (step_ff == STEP_LAST) begin
               case (ret_ff)
                  RET_PAD: state_in = ST_PAD;
                  RET_OUT: begin
                     state_in = ST_ORD;
                     oidx_in  = 3'd0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ORD: begin
            hrd_addr = oidx_ff;
            state_in = ST_OLOAD;
         end
         ST_OLOAD: begin
            hrd_addr     = oidx_ff;
            rsp_valid_in = 1'b1;
            rsp_data_in  = hword;
            rsp_idx_in   = oidx_ff;
            rsp_last_in  = (oidx_ff == 3'(sha256_pkg::HASH_WORDS - 1));
            state_in     = ST_OWAIT;
         end
         ST_OWAIT: begin
            hrd_addr = oidx_ff;
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  hval_in  = '0;
                  count_in = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  oidx_in  = oidx_ff + 3'd1;
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         mark_ff      <= 1'b0;
         lenph_ff     <= 1'b0;
         step_ff      <= '0;
         rnd_ff       <= '0;
         oidx_ff      <= '0;
         hval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         lenph_ff     <= lenph_in;
         step_ff      <= step_in;
         rnd_ff       <= rnd_in;
         oidx_ff      <= oidx_in;
         hval_ff      <= hval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff     <= part_in;
      wv_ff       <= wv_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (put_en && (fill_ff[1:0] == 2'd3)) begin
         bmem[fill_ff[5:2]] <= {part_ff, put_byte};
      end
      bq_ff <= bmem[brd_addr];
   end

   always_ff @(posedge clock) begin
      if (hwr_en) begin
         hmem[hwr_addr] <= hwr_data;
      end
      hq_ff  <= hmem[hrd_addr];
      hqv_ff <= hval_ff[hrd_addr];
      hqa_ff <= hrd_addr;
   end

   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a digest word is pending");

   a_rounds_empty_buffer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (fill_ff == 6'd0))
      else $error("block buffer not empty during rounds");

   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("end of message did not start padding");

   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && hval_ff == 8'd0))
      else $error("hasher did not restart after the last digest word");

endmodule

// ----- verif/sha256_stream_hasher_test.sv -----
module sha256_stream_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef sha256_pkg::word_type word_type;
   typedef sha256_pkg::byte_type byte_type;

   typedef struct packed {
      byte_type data;
      logic     present;
      logic     ends;
   } byte_req_type;

   typedef struct packed {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_exp_type;

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam word_type HASH_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam int MAX_WAIT      = 18;
   localparam int STALL_CYCLES  = 400;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   sha256_stream_hasher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   byte_req_type   pending_reqs [$];
   digest_exp_type digest_queue [$];

   word_type    hash_state [0:7];
   byte_type    block_bytes [0:63];
   int          block_fill;
   logic [60:0] msg_len;

   int   error_count = 0;
   int   req_count = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic hold_rsp = 1'b0;

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic word_type ror32(input word_type v, input int sh);
      logic [63:0] both;
      both = {v, v} >> sh;
      return both[31:0];
   endfunction

   task automatic compress_block();
      word_type w [0:63];
      word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) begin
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic absorb_byte(input byte_type b);
      block_bytes[block_fill] = b;
      block_fill = (block_fill + 1) % 64;
      if (block_fill == 0) compress_block();
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
      block_fill = 0;
      msg_len = '0;
   endtask

   task automatic absorb_request(input byte_type data, input logic present, input logic ends);
      logic [63:0] bit_len;
      digest_exp_type exp_word;
      if (present) begin
         absorb_byte(data);
         msg_len = msg_len + 61'd1;
      end
      if (ends) begin
         bit_len = {msg_len, 3'b000};
         absorb_byte(8'h80);
         while (block_fill != 56) absorb_byte(8'h00);
         for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
         for (int i = 0; i < 8; i++) begin
            exp_word.word  = hash_state[i];
            exp_word.index = 3'(i);
            exp_word.last  = (i == 7);
            digest_queue.push_back(exp_word);
         end
         restart_hash();
      end
   endtask

   task automatic add_item(input byte_type data, input logic present, input logic ends);
      byte_req_type item;
      item.data    = data;
      item.present = present;
      item.ends    = ends;
      pending_reqs.push_back(item);
   endtask

   // Monitor: response check first so a request's own digest is never matched early.
   always @(posedge clock) begin
      digest_exp_type head;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               flag_mismatch($sformatf("unexpected digest word %h", rsp_tdata));
            end else begin
               head = digest_queue.pop_front();
               if (rsp_tdata !== head.word)
                  flag_mismatch($sformatf("word %0d digest %h, expected %h",
                                          head.index, rsp_tdata, head.word));
               if (rsp_tuser !== head.index)
                  flag_mismatch($sformatf("word index %0d, expected %0d",
                                          rsp_tuser, head.index));
               if (rsp_tlast !== head.last)
                  flag_mismatch($sformatf("word %0d last %b, expected %b",
                                          head.index, rsp_tlast, head.last));
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_request(req_tdata, req_tuser, req_tlast);
            req_count <= req_count + 1;
         end
      end
   end

   // Request driver
   int  req_gap = 0;
   bit  req_idle_mode = 1'b1;
   byte_req_type req_cur = '0;

   always @(negedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid && !req_fire;
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               req_cur = pending_reqs.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 19) == 0) req_idle_mode = !req_idle_mode;
               req_gap = req_idle_mode ? $urandom_range(0, MAX_WAIT) : 0;
            end
         end
         req_tvalid <= next_valid;
         req_tdata  <= req_cur.data;
         req_tuser  <= req_cur.present;
         req_tlast  <= req_cur.ends;
      end
   end

   // Response receiver
   int rsp_wait = 0;
   bit rsp_idle_mode = 1'b1;

   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         w = rsp_wait;
         if (rsp_fire) begin
            if ($urandom_range(0, 11) == 0) rsp_idle_mode = !rsp_idle_mode;
            w = rsp_idle_mode ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (w > 0) begin
            rsp_tready <= 1'b0;
            w--;
         end else begin
            rsp_tready <= 1'b1;
         end
         rsp_wait = w;
      end
   end

   // Long receiver hold-off while requests keep coming
   initial begin
      wait (req_count >= 60);
      @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (STALL_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int random_items;
      int len;
      int pick;
      int tail;
      bit end_on_byte;
      byte_type data;

      restart_hash();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

      // directed: empty message, single extreme bytes, idle items, bare end after bytes, "abc"
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'hff, 1'b0, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hff, 1'b1, 1'b1);
      add_item(8'ha5, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(8'h5a, 1'b1, 1'b0);
      add_item(8'hff, 1'b0, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'hff, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'hff, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);

      // random messages, lengths weighted toward short ones and padding boundaries
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            len = $urandom_range(0, 12);
         end else if (pick < 8) begin
            case ($urandom_range(0, 7))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               default: len = 120;
            endcase
         end else begin
            len = $urandom_range(13, 70);
         end
         end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               add_item(byte_type'($urandom_range(0, 255)), 1'b0, 1'b0);
               random_items++;
            end
            case ($urandom_range(0, 15))
               0: data = 8'h00;
               1: data = 8'hff;
               default: data = byte_type'($urandom_range(0, 255));
            endcase
            add_item(data, 1'b1, end_on_byte && (i == len - 1));
            random_items++;
         end
         if (!end_on_byte) begin
            add_item(byte_type'($urandom_range(0, 255)), 1'b0, 1'b1);
            random_items++;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      tail = 0;
      while (digest_queue.size() != 0 && tail < DRAIN_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      repeat (200) @(posedge clock);
      if (digest_queue.size() != 0)
         flag_mismatch($sformatf("%0d digest words never arrived", digest_queue.size()));

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
